// File: rtl/sstd_pkg.sv
// Shared constants and types for the swing structure trend detector.
`timescale 1ns / 1ps

package sstd_pkg;

    localparam int MaxStrength = 8;
    localparam int MaxSwings   = 64;

    localparam int WinDepth = 2 * MaxStrength + 1;
    localparam int SeenCap  = 4 * MaxStrength;
    localparam int IdxW     = $clog2(WinDepth);
    localparam int SeenW    = $clog2(SeenCap + 1);
    localparam int StrW     = $clog2(MaxStrength + 1);
    localparam int CntW     = $clog2(MaxSwings + 1);

    localparam int PriceW   = 32;
    localparam int CfgStrW  = 4;
    localparam int StrReset = 3;
    localparam int AddrW    = 3;
    localparam int DataW    = 32;

    localparam logic [AddrW-3:0] RegStrength = '0;

    localparam logic [6:0] ConfStrong = 7'd90;
    localparam logic [6:0] ConfPlain  = 7'd70;
    localparam logic [6:0] ConfRange  = 7'd40;

    typedef enum logic [2:0] {
        TREND_STRONG_BULL = 3'd0,
        TREND_BULL        = 3'd1,
        TREND_RANGING     = 3'd2,
        TREND_BEAR        = 3'd3,
        TREND_STRONG_BEAR = 3'd4
    } trend_t;

    typedef logic [PriceW-1:0] price_t;

endpackage

// File: rtl/swing_structure_trend_detector.sv
// Top level: swing high/low detection and market structure trend classification.
// Bars are registered at the input; compare and swing update are combinational, and the
// result is registered. Throughput: one bar per cycle unless out_stall holds a result.
// The swing state is read and written in the same cycle, so bars follow back to back.
// Reset (rst_n low, asynchronous) clears the windows, counters, swing prices and
// pipeline valids, and sets the strength register to 3.
`timescale 1ns / 1ps

module swing_structure_trend_detector (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sstd_pkg::AddrW-1:0]      paddr,
    input  logic [sstd_pkg::DataW-1:0]      pwdata,
    output logic [sstd_pkg::DataW-1:0]      prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [31:0]                     bar_high,
    input  logic [31:0]                     bar_low,
    input  logic [31:0]                     bar_close,
    input  logic                            start_series,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      trend_code,
    output logic signed [1:0]               direction_signal,
    output logic [6:0]                      confidence_pct,
    output logic                            structure_break,
    output logic [31:0]                     recent_swing_high,
    output logic [31:0]                     recent_swing_low,
    output logic [6:0]                      high_swings_found,
    output logic [6:0]                      low_swings_found
);

    localparam int WinDepth = sstd_pkg::WinDepth;
    localparam int IdxW     = sstd_pkg::IdxW;
    localparam int SeenW    = sstd_pkg::SeenW;
    localparam int StrW     = sstd_pkg::StrW;
    localparam int CntW     = sstd_pkg::CntW;

    // configuration
    logic [sstd_pkg::CfgStrW-1:0] strength_reg;
    logic                         cfg_write;

    // input stage
    logic             s1_valid_reg;
    sstd_pkg::price_t s1_high_reg;
    sstd_pkg::price_t s1_low_reg;
    sstd_pkg::price_t s1_close_reg;
    logic             s1_start_reg;
    logic             advance;
    logic             step;

    // series state
    sstd_pkg::price_t hi_win_reg [WinDepth];
    sstd_pkg::price_t lo_win_reg [WinDepth];
    sstd_pkg::price_t hi_win_next [WinDepth];
    sstd_pkg::price_t lo_win_next [WinDepth];
    logic [SeenW-1:0] bars_reg, bars_next;
    sstd_pkg::price_t sh_latest_reg, sh_latest_next;
    sstd_pkg::price_t sh_earlier_reg, sh_earlier_next;
    sstd_pkg::price_t sl_latest_reg, sl_latest_next;
    sstd_pkg::price_t sl_earlier_reg, sl_earlier_next;
    logic [CntW-1:0]  sh_cnt_reg, sh_cnt_next;
    logic [CntW-1:0]  sl_cnt_reg, sl_cnt_next;

    // result stage
    logic             out_valid_reg;
    sstd_pkg::trend_t trend_reg, trend_next;
    logic signed [1:0] sig_reg, sig_next;
    logic [6:0]       conf_reg, conf_next;
    logic             brk_reg, brk_next;
    sstd_pkg::price_t rsh_reg, rsh_next;
    sstd_pkg::price_t rsl_reg, rsl_next;
    logic [6:0]       hc_reg, hc_next;
    logic [6:0]       lc_reg, lc_next;

    logic [StrW-1:0]  s_eff;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= sstd_pkg::CfgStrW'(sstd_pkg::StrReset);
        end
        else if (cfg_write && (paddr[sstd_pkg::AddrW-1:2] == sstd_pkg::RegStrength))
        begin
            strength_reg <= pwdata[sstd_pkg::CfgStrW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[sstd_pkg::AddrW-1:2] == sstd_pkg::RegStrength)
        begin
            prdata = {{(sstd_pkg::DataW - sstd_pkg::CfgStrW){1'b0}}, strength_reg};
        end
    end

    always_comb
    begin
        if (strength_reg == '0)
        begin
            s_eff = StrW'(1);
        end
        else if (int'(strength_reg) > sstd_pkg::MaxStrength)
        begin
            s_eff = StrW'(sstd_pkg::MaxStrength);
        end
        else
        begin
            s_eff = StrW'(strength_reg);
        end
    end

    // ---------------------------------------------------------------- handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign step     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_high_reg  <= bar_high;
            s1_low_reg   <= bar_low;
            s1_close_reg <= bar_close;
            s1_start_reg <= start_series;
        end
    end

    // ---------------------------------------------------------------- analysis
    always_comb
    begin
        sstd_pkg::price_t sh_base_latest;
        sstd_pkg::price_t sl_base_latest;
        sstd_pkg::price_t sh_base_earlier;
        sstd_pkg::price_t sl_base_earlier;
        sstd_pkg::price_t ch;
        sstd_pkg::price_t cw;
        logic [CntW-1:0]  sh_base_cnt;
        logic [CntW-1:0]  sl_base_cnt;
        logic             is_sh;
        logic             is_sl;
        logic             confirm;
        logic             warm;
        logic             hh, hl, lh, ll;

        // shift the new bar in at the newest slot; a start bar sees a cleared window
        hi_win_next[0] = s1_high_reg;
        lo_win_next[0] = s1_low_reg;
        for (int i = 1; i < WinDepth; i++)
        begin
            hi_win_next[i] = s1_start_reg ? '0 : hi_win_reg[i-1];
            lo_win_next[i] = s1_start_reg ? '0 : lo_win_reg[i-1];
        end

        if (s1_start_reg)
        begin
            bars_next = SeenW'(1);
        end
        else if (int'(bars_reg) < sstd_pkg::SeenCap)
        begin
            bars_next = bars_reg + SeenW'(1);
        end
        else
        begin
            bars_next = bars_reg;
        end

        sh_base_latest  = s1_start_reg ? '0 : sh_latest_reg;
        sh_base_earlier = s1_start_reg ? '0 : sh_earlier_reg;
        sl_base_latest  = s1_start_reg ? '0 : sl_latest_reg;
        sl_base_earlier = s1_start_reg ? '0 : sl_earlier_reg;
        sh_base_cnt     = s1_start_reg ? '0 : sh_cnt_reg;
        sl_base_cnt     = s1_start_reg ? '0 : sl_cnt_reg;

        // candidate is the bar s_eff back; compare against s_eff bars each side
        ch    = hi_win_next[IdxW'(s_eff)];
        cw    = lo_win_next[IdxW'(s_eff)];
        is_sh = 1'b1;
        is_sl = 1'b1;
        for (int k = 1; k <= sstd_pkg::MaxStrength; k++)
        begin
            if (k <= int'(s_eff))
            begin
                if (ch <= hi_win_next[IdxW'(int'(s_eff) - k)] ||
                    ch <= hi_win_next[IdxW'(int'(s_eff) + k)])
                begin
                    is_sh = 1'b0;
                end
                if (cw >= lo_win_next[IdxW'(int'(s_eff) - k)] ||
                    cw >= lo_win_next[IdxW'(int'(s_eff) + k)])
                begin
                    is_sl = 1'b0;
                end
            end
        end

        confirm = int'(bars_next) >= 2 * int'(s_eff) + 1;

        sh_latest_next  = sh_base_latest;
        sh_earlier_next = sh_base_earlier;
        sh_cnt_next     = sh_base_cnt;
        if (confirm && is_sh && (int'(sh_base_cnt) < sstd_pkg::MaxSwings))
        begin
            sh_earlier_next = sh_base_latest;
            sh_latest_next  = ch;
            sh_cnt_next     = sh_base_cnt + CntW'(1);
        end

        sl_latest_next  = sl_base_latest;
        sl_earlier_next = sl_base_earlier;
        sl_cnt_next     = sl_base_cnt;
        if (confirm && is_sl && (int'(sl_base_cnt) < sstd_pkg::MaxSwings))
        begin
            sl_earlier_next = sl_base_latest;
            sl_latest_next  = cw;
            sl_cnt_next     = sl_base_cnt + CntW'(1);
        end

        // result defaults
        trend_next = sstd_pkg::TREND_RANGING;
        sig_next   = 2'sd0;
        conf_next  = sstd_pkg::ConfRange;
        brk_next   = 1'b0;
        rsh_next   = '0;
        rsl_next   = '0;
        hc_next    = '0;
        lc_next    = '0;

        warm = int'(bars_next) >= 4 * int'(s_eff);
        hh = sh_latest_next > sh_earlier_next;
        hl = sl_latest_next > sl_earlier_next;
        lh = sh_latest_next < sh_earlier_next;
        ll = sl_latest_next < sl_earlier_next;

        if (warm)
        begin
            hc_next = 7'(sh_cnt_next);
            lc_next = 7'(sl_cnt_next);
            if ((int'(sh_cnt_next) >= 2) && (int'(sl_cnt_next) >= 2))
            begin
                if (hh && hl)
                begin
                    trend_next = sstd_pkg::TREND_STRONG_BULL;
                    sig_next   = 2'sd1;
                    conf_next  = sstd_pkg::ConfStrong;
                end
                else if (hh || hl)
                begin
                    trend_next = sstd_pkg::TREND_BULL;
                    sig_next   = 2'sd1;
                    conf_next  = sstd_pkg::ConfPlain;
                end
                else if (ll && lh)
                begin
                    trend_next = sstd_pkg::TREND_STRONG_BEAR;
                    sig_next   = -2'sd1;
                    conf_next  = sstd_pkg::ConfStrong;
                end
                else if (ll || lh)
                begin
                    trend_next = sstd_pkg::TREND_BEAR;
                    sig_next   = -2'sd1;
                    conf_next  = sstd_pkg::ConfPlain;
                end
                rsh_next = sh_latest_next;
                rsl_next = sl_latest_next;

                // a close through the opposing swing reverses the signal
                case (trend_next)
                    sstd_pkg::TREND_STRONG_BULL,
                    sstd_pkg::TREND_BULL:        brk_next = s1_close_reg < sl_latest_next;
                    sstd_pkg::TREND_BEAR,
                    sstd_pkg::TREND_STRONG_BEAR: brk_next = s1_close_reg > sh_latest_next;
                    default:                     brk_next = 1'b0;
                endcase
                if (brk_next)
                begin
                    sig_next = -sig_next;
                end
            end
        end
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                hi_win_reg[i] <= '0;
                lo_win_reg[i] <= '0;
            end
            bars_reg       <= '0;
            sh_latest_reg  <= '0;
            sh_earlier_reg <= '0;
            sl_latest_reg  <= '0;
            sl_earlier_reg <= '0;
            sh_cnt_reg     <= '0;
            sl_cnt_reg     <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                hi_win_reg[i] <= hi_win_next[i];
                lo_win_reg[i] <= lo_win_next[i];
            end
            bars_reg       <= bars_next;
            sh_latest_reg  <= sh_latest_next;
            sh_earlier_reg <= sh_earlier_next;
            sl_latest_reg  <= sl_latest_next;
            sl_earlier_reg <= sl_earlier_next;
            sh_cnt_reg     <= sh_cnt_next;
            sl_cnt_reg     <= sl_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            trend_reg <= trend_next;
            sig_reg   <= sig_next;
            conf_reg  <= conf_next;
            brk_reg   <= brk_next;
            rsh_reg   <= rsh_next;
            rsl_reg   <= rsl_next;
            hc_reg    <= hc_next;
            lc_reg    <= lc_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign trend_code        = trend_reg;
    assign direction_signal  = sig_reg;
    assign confidence_pct    = conf_reg;
    assign structure_break   = brk_reg;
    assign recent_swing_high = rsh_reg;
    assign recent_swing_low  = rsl_reg;
    assign high_swings_found = hc_reg;
    assign low_swings_found  = lc_reg;

    // ---------------------------------------------------------------- checks
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(sh_cnt_reg) <= sstd_pkg::MaxSwings) && (int'(sl_cnt_reg) <= sstd_pkg::MaxSwings))
        else $error("swing count beyond cap");

    a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(bars_reg) <= sstd_pkg::SeenCap)
        else $error("bar count beyond cap");

    a_range_no_break: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (trend_reg == sstd_pkg::TREND_RANGING)
        |-> !brk_reg && (sig_reg == 2'sd0) && (conf_reg == sstd_pkg::ConfRange))
        else $error("ranging result with break or signal");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(bars_reg) && $stable(sh_cnt_reg) && $stable(sl_cnt_reg))
        else $error("series state changed without a transaction");

endmodule

// File: dv/trend_result_monitor.sv
// Monitor for the swing structure trend detector: predicts each analysis and compares it.
`timescale 1ns / 1ps

module trend_result_monitor
    import sstd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [DataW-1:0]   pwdata,
    input  logic [DataW-1:0]   prdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  price_t             bar_high,
    input  price_t             bar_low,
    input  price_t             bar_close,
    input  logic               start_series,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         trend_code,
    input  logic signed [1:0]  direction_signal,
    input  logic [6:0]         confidence_pct,
    input  logic               structure_break,
    input  price_t             recent_swing_high,
    input  price_t             recent_swing_low,
    input  logic [6:0]         high_swings_found,
    input  logic [6:0]         low_swings_found,
    output int                 mismatch_count,
    output int                 analyses_pending,
    output int                 analyses_checked,
    output int                 breaks_seen,
    output int                 capped_seen,
    output logic [4:0]         trends_seen
);

    localparam logic [AddrW-1:0] StrengthAddr = {RegStrength, 2'b00};

    typedef struct packed {
        trend_t            trend;
        logic signed [1:0] sig;
        logic [6:0]        conf;
        logic              brk;
        price_t            swing_hi;
        price_t            swing_lo;
        logic [6:0]        hi_count;
        logic [6:0]        lo_count;
    } analysis_t;

    logic [CfgStrW-1:0] strength_reg;
    price_t             hi_win [WinDepth];
    price_t             lo_win [WinDepth];
    int                 bars_in;
    int                 sh_total;
    int                 sl_total;
    price_t             sh_new;
    price_t             sh_old;
    price_t             sl_new;
    price_t             sl_old;
    analysis_t          expected_analysis_q [$];

    function automatic void clear_series();
        int k;
        for (k = 0; k < WinDepth; k++)
        begin
            hi_win[k] = '0;
            lo_win[k] = '0;
        end
        bars_in  = 0;
        sh_total = 0;
        sl_total = 0;
        sh_new   = '0;
        sh_old   = '0;
        sl_new   = '0;
        sl_old   = '0;
    endfunction

    function automatic analysis_t analyze_bar(price_t hi, price_t lo, price_t cl, logic start);
        analysis_t a;
        int        s;
        int        k;
        logic      is_sh;
        logic      is_sl;
        logic      hh;
        logic      hl;
        logic      lh;
        logic      ll;
        // 0 behaves as 1, anything above MaxStrength as MaxStrength
        s = (strength_reg == 0) ? 1 :
            ((strength_reg > MaxStrength) ? MaxStrength : int'(strength_reg));
        a.trend    = TREND_RANGING;
        a.sig      = 2'sd0;
        a.conf     = ConfRange;
        a.brk      = 1'b0;
        a.swing_hi = '0;
        a.swing_lo = '0;
        a.hi_count = '0;
        a.lo_count = '0;
        if (start)
            clear_series();
        for (k = WinDepth - 1; k > 0; k--)
        begin
            hi_win[k] = hi_win[k-1];
            lo_win[k] = lo_win[k-1];
        end
        hi_win[0] = hi;
        lo_win[0] = lo;
        if (bars_in < SeenCap)
            bars_in++;

        // bar s back needs s neighbors on both sides before it can be judged
        if (bars_in >= 2 * s + 1)
        begin
            is_sh = 1'b1;
            is_sl = 1'b1;
            for (k = 1; k <= s; k++)
            begin
                if (hi_win[s] <= hi_win[s-k] || hi_win[s] <= hi_win[s+k])
                    is_sh = 1'b0;
                if (lo_win[s] >= lo_win[s-k] || lo_win[s] >= lo_win[s+k])
                    is_sl = 1'b0;
            end
            if (is_sh && sh_total < MaxSwings)
            begin
                sh_old = sh_new;
                sh_new = hi_win[s];
                sh_total++;
            end
            if (is_sl && sl_total < MaxSwings)
            begin
                sl_old = sl_new;
                sl_new = lo_win[s];
                sl_total++;
            end
        end

        if (bars_in >= 4 * s)
        begin
            a.hi_count = 7'(sh_total);
            a.lo_count = 7'(sl_total);
            if (sh_total >= 2 && sl_total >= 2)
            begin
                hh = sh_new > sh_old;
                hl = sl_new > sl_old;
                lh = sh_new < sh_old;
                ll = sl_new < sl_old;
                if (hh && hl)
                begin
                    a.trend = TREND_STRONG_BULL;
                    a.sig   = 2'sd1;
                    a.conf  = ConfStrong;
                end
                else if (hh || hl)
                begin
                    a.trend = TREND_BULL;
                    a.sig   = 2'sd1;
                    a.conf  = ConfPlain;
                end
                else if (ll && lh)
                begin
                    a.trend = TREND_STRONG_BEAR;
                    a.sig   = -2'sd1;
                    a.conf  = ConfStrong;
                end
                else if (ll || lh)
                begin
                    a.trend = TREND_BEAR;
                    a.sig   = -2'sd1;
                    a.conf  = ConfPlain;
                end
                a.swing_hi = sh_new;
                a.swing_lo = sl_new;
                // close through the opposing swing flips the signal
                if (a.trend == TREND_BEAR || a.trend == TREND_STRONG_BEAR)
                    a.brk = cl > sh_new;
                else if (a.trend == TREND_BULL || a.trend == TREND_STRONG_BULL)
                    a.brk = cl < sl_new;
                if (a.brk)
                    a.sig = -a.sig;
            end
        end
        return a;
    endfunction

    task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        analysis_t want;
        if (!rst_n)
        begin
            strength_reg = CfgStrW'(StrReset);
            clear_series();
            expected_analysis_q.delete();
            mismatch_count   = 0;
            analyses_pending = 0;
            analyses_checked = 0;
            breaks_seen      = 0;
            capped_seen      = 0;
            trends_seen      = '0;
        end
        else
        begin
            if (psel && penable && pready && paddr == StrengthAddr)
            begin
                if (pwrite)
                    strength_reg = pwdata[CfgStrW-1:0];
                else
                    check_field("strength_cfg", strength_reg, prdata);
            end

            // results first: a result at this edge belongs to an older transaction
            if (out_valid && !out_stall)
            begin
                if (expected_analysis_q.size() == 0)
                begin
                    $error("analysis transaction arrived with none expected");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_analysis_q.pop_front();
                    check_field("trend_code", want.trend, trend_code);
                    check_field("direction_signal", want.sig, direction_signal);
                    check_field("confidence_pct", want.conf, confidence_pct);
                    check_field("structure_break", want.brk, structure_break);
                    check_field("recent_swing_high", want.swing_hi, recent_swing_high);
                    check_field("recent_swing_low", want.swing_lo, recent_swing_low);
                    check_field("high_swings_found", want.hi_count, high_swings_found);
                    check_field("low_swings_found", want.lo_count, low_swings_found);
                    analyses_checked++;
                    trends_seen[int'(want.trend)] = 1'b1;
                    if (want.brk)
                        breaks_seen++;
                    if (want.hi_count == MaxSwings || want.lo_count == MaxSwings)
                        capped_seen++;
                end
            end

            if (in_valid && !in_stall)
                expected_analysis_q.push_back(
                    analyze_bar(bar_high, bar_low, bar_close, start_series));

            analyses_pending = expected_analysis_q.size();
        end
    end

endmodule

// File: dv/swing_structure_trend_detector_test.sv
// Top of the swing structure trend detector testbench: clock, reset, bar stimulus, verdict.
`timescale 1ns / 1ps

module swing_structure_trend_detector_test;
    import sstd_pkg::*;

    localparam logic [AddrW-1:0] StrengthAddr = {RegStrength, 2'b00};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [DataW-1:0]   pwdata;
    logic [DataW-1:0]   prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    price_t             bar_high;
    price_t             bar_low;
    price_t             bar_close;
    logic               start_series;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         trend_code;
    logic signed [1:0]  direction_signal;
    logic [6:0]         confidence_pct;
    logic               structure_break;
    price_t             recent_swing_high;
    price_t             recent_swing_low;
    logic [6:0]         high_swings_found;
    logic [6:0]         low_swings_found;

    int                 mismatch_count;
    int                 analyses_pending;
    int                 analyses_checked;
    int                 breaks_seen;
    int                 capped_seen;
    logic [4:0]         trends_seen;

    int                 send_gap_pct;
    int                 stall_pct;
    int                 bars_sent;

    swing_structure_trend_detector u_dut (.*);

    trend_result_monitor u_monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic price_t clip(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(32'hFFFF_FFFF))
            return '1;
        return price_t'(v);
    endfunction

    task automatic send_bar(price_t h, price_t l, price_t c, logic st);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        bar_high     <= h;
        bar_low      <= l;
        bar_close    <= c;
        start_series <= st;
        do
            @(posedge clk);
        while (in_stall);
        bars_sent++;
    endtask

    task automatic apb_access(logic wr, logic [DataW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= StrengthAddr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold off bars until every analysis is back, then change the strength
    task automatic drain_and_set_strength(int str);
        @(negedge clk);
        in_valid <= 1'b0;
        while (analyses_pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        apb_access(1'b1, DataW'(str));
        apb_access(1'b0, '0);
    endtask

    // triangle wave with drift; flare widens or narrows the bar range over time
    task automatic run_series(int n, logic fresh, int force_hp);
        int     hp;
        int     amp;
        int     drift;
        int     flare;
        int     wick;
        int     i;
        int     pos;
        int     tri_pos;
        longint base;
        longint mid;
        logic   st;
        hp = (force_hp != 0) ? force_hp :
             (($urandom_range(0, 1) == 1) ? $urandom_range(1, 4) :
                                            $urandom_range(1, 2 * MaxStrength));
        amp   = $urandom_range(25, 5000);
        drift = int'($urandom_range(0, 40)) - 20;
        if ($urandom_range(0, 3) == 0)
            drift = 0;
        flare = int'($urandom_range(0, 6)) - 3;
        wick  = $urandom_range(0, 2000);
        base  = ($urandom_range(0, 7) == 0) ? longint'($urandom()) :
                longint'($urandom_range(100000, 100000000));
        for (i = 0; i < n; i++)
        begin
            pos     = i % (2 * hp);
            tri_pos = (pos < hp) ? pos : 2 * hp - pos;
            mid     = base + longint'(drift) * i + longint'(amp) * tri_pos;
            st      = (fresh && i == 0) || ($urandom_range(0, 399) == 0);
            if ($urandom_range(0, 99) < 8)
                send_bar($urandom(), $urandom(), $urandom(), st);
            else
                send_bar(clip(mid + wick + longint'(flare) * i),
                         clip(mid - wick - longint'(flare) * i),
                         clip(mid + int'($urandom_range(0, 4 * amp * hp)) - 2 * amp * hp),
                         st);
        end
    endtask

    initial
    begin
        int     phase;
        int     blk;
        int     n;
        int     i;
        int     h;
        int     target;
        int     plan [8];
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        bar_high     = '0;
        bar_low      = '0;
        bar_close    = '0;
        start_series = 1'b0;
        send_gap_pct = 6;
        stall_pct    = 80;
        bars_sent    = 0;
        plan         = '{1, 8, 0, 15, 3, 2, 9, 5};
        rst_n        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, '0);
        drain_and_set_strength(1);

        // extremes, then strong bull with a break, strong bear with a break, ranging
        send_bar('1, '0, '1, 1'b1);
        send_bar('0, '1, '0, 1'b0);
        for (i = 0; i < 8; i++)
        begin
            h = 1000 + 100 * i + ((i % 2 == 1) ? 500 : 0);
            send_bar(h, h - 50, (i == 7) ? '0 : price_t'(h - 20), 1'b0);
        end
        for (i = 0; i < 9; i++)
        begin
            h = 5000 - 100 * i + ((i % 2 == 1) ? 500 : 0);
            send_bar(h, h - 50, (i == 8) ? '1 : price_t'(h - 20), 1'b0);
        end
        for (i = 0; i < 6; i++)
        begin
            h = (i % 2 == 1) ? 2000 : 3000;
            send_bar(h, h - 50, h - 20, 1'b0);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_gap_pct = (phase == 0) ? 6 : ((phase == 1) ? 80 : 0);
            stall_pct    = (phase == 0) ? 80 : ((phase == 1) ? 6 : 0);
            target       = 484 * (phase + 1);
            blk          = 0;
            while (bars_sent < target)
            begin
                drain_and_set_strength((blk < 8) ? plan[blk] : $urandom_range(0, 15));
                if (phase == 0 && blk == 0)
                begin
                    // zigzag long enough to run both swing counts into the cap
                    run_series(160, 1'b1, 1);
                end
                else
                begin
                    n = $urandom_range(30, 220);
                    if (n > target - bars_sent)
                        n = target - bars_sent;
                    run_series(n, $urandom_range(0, 3) != 0, 0);
                end
                blk++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        for (i = 0; i < 100000 && analyses_pending != 0; i++)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (analyses_pending != 0)
            $error("%0d analyses never arrived", analyses_pending);

        $display("Sent %0d bars, checked %0d analyses over strengths 0..15 and three idle mixes.",
                 bars_sent, analyses_checked);
        $display("Trend codes hit (one bit each) %b, structure breaks %0d, at swing cap %0d.",
                 trends_seen, breaks_seen, capped_seen);
        if (mismatch_count == 0 && analyses_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
